// ===== src/rmes_pkg.sv =====
// Shared constants, operation codes and helper functions of the register machine execute step.
package rmes_pkg;

	localparam int REG_COUNT     = 16;
	localparam int PROGRAM_DEPTH = 1024;

	localparam int DATA_W    = 64;
	localparam int FIELD_W   = 32;
	localparam int LEN_W     = 11;
	localparam int OUT_PC_W  = 10;
	localparam int MUL_CNT_W = 32;
	localparam int IDX_W     = $clog2(REG_COUNT);
	localparam int PC_W      = $clog2(PROGRAM_DEPTH);

	typedef logic [1:0]          op_t;
	typedef logic [DATA_W-1:0]   word_t;
	typedef logic [IDX_W-1:0]    idx_t;
	typedef logic [PC_W-1:0]     pc_t;
	typedef logic [LEN_W-1:0]    len_t;

	localparam op_t OP_SET = 2'd0;
	localparam op_t OP_SUB = 2'd1;
	localparam op_t OP_MUL = 2'd2;
	localparam op_t OP_JNZ = 2'd3;

	localparam logic [MUL_CNT_W-1:0] MUL_CNT_MAX = '1;

	// Widen a 32-bit immediate with its sign.
	function automatic word_t sext_field(input logic [FIELD_W-1:0] v);
		return {{(DATA_W-FIELD_W){v[FIELD_W-1]}}, v};
	endfunction

	// An index, as an unsigned 32-bit pattern, names a real register.
	function automatic logic idx_in_range(input logic [FIELD_W-1:0] v);
		return v < FIELD_W'(REG_COUNT);
	endfunction

endpackage

// ===== src/register_machine_execute_step.sv =====
// Execute step of a set / subtract / multiply / jump-if-nonzero register machine.
//
// One decoded instruction enters per beat on the in_* channel (valid/ready) and
// one result leaves per instruction on the out_* channel (valid/ready), in order.
// The register file is read as the beat is accepted into the input stage, and the
// instruction then executes from the input stage, loading the output register.
// Set, subtract and jump sustain one instruction per cycle while the output is
// not stalled; a multiply holds its slot in the input stage, so no new instruction
// enters, while the 64-bit product is built from three 32x32 partial products on
// one shared multiplier. A write to a register is forwarded to the read of the
// following instruction, so no bubbles appear between dependent instructions.
// cfg_we writes program_length from cfg_wdata; write it only while idle.
// Reset clears the register file (through per-register valid bits), the program
// counter, the stop flag and the multiply count; program_length resets to zero,
// so the machine reads as halted until a length is written.
// When the receiver stalls, the result holds in the output register, one more
// instruction may be accepted and waits in the input stage, and then in_ready
// falls until the result beat is taken.
module register_machine_execute_step (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [rmes_pkg::LEN_W-1:0]        cfg_wdata,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [1:0]                        op_code,
	input  logic                              first_is_immediate,
	input  logic signed [rmes_pkg::FIELD_W-1:0] first_operand,
	input  logic                              second_is_immediate,
	input  logic signed [rmes_pkg::FIELD_W-1:0] second_operand,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [rmes_pkg::OUT_PC_W-1:0]     next_counter,
	output logic                              halted,
	output logic signed [rmes_pkg::DATA_W-1:0]  written_value,
	output logic [rmes_pkg::MUL_CNT_W-1:0]    multiply_total
);
	import rmes_pkg::*;

	// architectural state
	word_t                  rf_mem [REG_COUNT];
	logic [REG_COUNT-1:0]   rf_vld_q;
	pc_t                    pc_q;
	logic                   stopped_q;
	logic [MUL_CNT_W-1:0]   mul_cnt_q;
	len_t                   prog_len_q;

	// input stage
	logic                   valid_s1;
	op_t                    op_s1;
	logic                   fi_s1;
	logic [FIELD_W-1:0]     fo_s1;
	logic                   si_s1;
	logic [FIELD_W-1:0]     so_s1;
	word_t                  rd_a_s1;
	word_t                  rd_b_s1;
	logic                   dst_ok_s1;

	// multiply sequencer
	logic [1:0]             mstep_q;
	word_t                  macc_q;

	// output register
	logic                   out_valid_q;
	logic [OUT_PC_W-1:0]    next_counter_q;
	logic                   halted_q;
	word_t                  written_q;
	logic [MUL_CNT_W-1:0]   mul_total_q;

	logic                   in_fire;
	logic                   exec_fire;
	logic                   halted_now;
	logic                   mul_need;
	word_t                  src;
	word_t                  test_val;
	word_t                  pc_w;
	word_t                  len_w;
	word_t                  target;
	logic                   target_ok;
	word_t                  written;
	logic                   wr_en;
	idx_t                   wr_idx;
	idx_t                   raddr_a;
	idx_t                   raddr_b;
	logic                   rok_a;
	logic                   rok_b;
	len_t                   eff_len;
	pc_t                    pc_next;
	logic                   stopped_next;
	logic [MUL_CNT_W-1:0]   mul_cnt_next;
	logic [FIELD_W-1:0]     mul_a;
	logic [FIELD_W-1:0]     mul_b;
	word_t                  mul_p;

	always_comb begin
		eff_len = (prog_len_q > LEN_W'(PROGRAM_DEPTH)) ? LEN_W'(PROGRAM_DEPTH) : prog_len_q;
		pc_w    = DATA_W'(pc_q);
		len_w   = DATA_W'(eff_len);
		halted_now = stopped_q || (pc_w >= len_w);

		src      = si_s1 ? sext_field(so_s1) : rd_b_s1;
		test_val = fi_s1 ? sext_field(fo_s1) : rd_a_s1;
		mul_need = valid_s1 && !halted_now && (op_s1 == OP_MUL);

		if ((op_s1 == OP_JNZ) && (test_val != '0)) begin
			target = pc_w + src;
		end else begin
			target = pc_w + DATA_W'(1);
		end
		target_ok = target < len_w;

		written = '0;
		if (!halted_now) begin
			case (op_s1)
				OP_SET:  written = src;
				OP_SUB:  written = rd_a_s1 - src;
				OP_MUL:  written = macc_q;
				default: written = '0;
			endcase
		end

		pc_next      = pc_q;
		stopped_next = stopped_q;
		mul_cnt_next = mul_cnt_q;
		if (!halted_now) begin
			if (target_ok) begin
				pc_next = target[PC_W-1:0];
			end else begin
				stopped_next = 1'b1;
			end
			if ((op_s1 == OP_MUL) && (mul_cnt_q != MUL_CNT_MAX)) begin
				mul_cnt_next = mul_cnt_q + MUL_CNT_W'(1);
			end
		end
	end

	// the instruction retires once the output register is free and, for a multiply, its product is complete
	assign exec_fire = valid_s1 && (!out_valid_q || out_ready) && (!mul_need || (mstep_q == 2'd3));
	assign in_ready  = !valid_s1 || exec_fire;
	assign in_fire   = in_valid && in_ready;

	assign wr_en  = exec_fire && !halted_now && (op_s1 != OP_JNZ) && dst_ok_s1;
	assign wr_idx = fo_s1[IDX_W-1:0];

	assign raddr_a = first_operand[IDX_W-1:0];
	assign raddr_b = second_operand[IDX_W-1:0];
	assign rok_a   = idx_in_range(first_operand);
	assign rok_b   = idx_in_range(second_operand);

	// partial products: lo*lo, then lo*hi and hi*lo into the upper half
	always_comb begin
		mul_a = (mstep_q == 2'd2) ? rd_a_s1[DATA_W-1:FIELD_W] : rd_a_s1[FIELD_W-1:0];
		mul_b = (mstep_q == 2'd1) ? src[DATA_W-1:FIELD_W] : src[FIELD_W-1:0];
		mul_p = DATA_W'(mul_a) * DATA_W'(mul_b);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mstep_q <= 2'd0;
		end else if (exec_fire) begin
			mstep_q <= 2'd0;
		end else if (mul_need && (mstep_q != 2'd3)) begin
			mstep_q <= mstep_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (mul_need && (mstep_q != 2'd3)) begin
			if (mstep_q == 2'd0) begin
				macc_q <= mul_p;
			end else begin
				macc_q[DATA_W-1:FIELD_W] <= macc_q[DATA_W-1:FIELD_W] + mul_p[FIELD_W-1:0];
			end
		end
	end

	// register file
	always_ff @(posedge clk) begin
		if (wr_en) begin
			rf_mem[wr_idx] <= written;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rf_vld_q <= '0;
		end else if (wr_en) begin
			rf_vld_q[wr_idx] <= 1'b1;
		end
	end

	// register read on acceptance, with the retiring write forwarded
	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_s1     <= op_code;
			fi_s1     <= first_is_immediate;
			fo_s1     <= first_operand;
			si_s1     <= second_is_immediate;
			so_s1     <= second_operand;
			dst_ok_s1 <= rok_a;
			if (!rok_a) begin
				rd_a_s1 <= '0;
			end else if (wr_en && (wr_idx == raddr_a)) begin
				rd_a_s1 <= written;
			end else if (rf_vld_q[raddr_a]) begin
				rd_a_s1 <= rf_mem[raddr_a];
			end else begin
				rd_a_s1 <= '0;
			end
			if (!rok_b) begin
				rd_b_s1 <= '0;
			end else if (wr_en && (wr_idx == raddr_b)) begin
				rd_b_s1 <= written;
			end else if (rf_vld_q[raddr_b]) begin
				rd_b_s1 <= rf_mem[raddr_b];
			end else begin
				rd_b_s1 <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (exec_fire) begin
			valid_s1 <= 1'b0;
		end
	end

	// machine state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q       <= '0;
			stopped_q  <= 1'b0;
			mul_cnt_q  <= '0;
			prog_len_q <= '0;
		end else begin
			if (cfg_we) begin
				prog_len_q <= cfg_wdata;
			end
			if (exec_fire) begin
				pc_q      <= pc_next;
				stopped_q <= stopped_next;
				mul_cnt_q <= mul_cnt_next;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (exec_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec_fire) begin
			next_counter_q <= OUT_PC_W'(DATA_W'(pc_next));
			halted_q       <= stopped_next || (DATA_W'(pc_next) >= len_w);
			written_q      <= written;
			mul_total_q    <= mul_cnt_next;
		end
	end

	assign out_valid      = out_valid_q;
	assign next_counter   = next_counter_q;
	assign halted         = halted_q;
	assign written_value  = written_q;
	assign multiply_total = mul_total_q;

endmodule

// ===== src/rmes_checker.sv =====
// Port-level checker for the register machine execute step, with its bind statement.
module rmes_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic                              in_ready,
	input  logic                              out_valid,
	input  logic                              out_ready,
	input  logic [rmes_pkg::OUT_PC_W-1:0]     next_counter,
	input  logic                              halted,
	input  logic signed [rmes_pkg::DATA_W-1:0]  written_value,
	input  logic [rmes_pkg::MUL_CNT_W-1:0]    multiply_total
);
	import rmes_pkg::*;

	logic [1:0]           pend_q;
	logic [MUL_CNT_W-1:0] last_total_q;
	logic                 in_beat;
	logic                 out_beat;

	assign in_beat  = in_valid && in_ready;
	assign out_beat = out_valid && out_ready;

	// count beats in flight and track the last delivered multiply count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q       <= 2'd0;
			last_total_q <= '0;
		end else begin
			pend_q <= pend_q + {1'b0, in_beat} - {1'b0, out_beat};
			if (out_beat) begin
				last_total_q <= multiply_total;
			end
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(next_counter) && $stable(halted)
			&& $stable(written_value) && $stable(multiply_total))
		else $error("stalled result beat changed");

	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != 2'd0)
		else $error("result beat without an instruction");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != 2'd3)
		else $error("more than two instructions in flight");

	a_mul_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (multiply_total >= last_total_q)
			&& ({1'b0, multiply_total} <= {1'b0, last_total_q} + 33'd1))
		else $error("multiply count moved by more than one per beat");

endmodule

bind register_machine_execute_step rmes_checker u_rmes_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_ready       (in_ready),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.next_counter   (next_counter),
	.halted         (halted),
	.written_value  (written_value),
	.multiply_total (multiply_total)
);

// ===== verif/rmes_result_check.sv =====
// Result checker for the register machine execute step: shadows the machine, predicts and compares.
`timescale 1ns / 100ps

module rmes_result_check (
	input  logic                                             clk,
	input  logic                                             arst_n,
	input  logic                                             cfg_we,
	input  rmes_pkg::len_t                                   cfg_wdata,
	input  logic                                             in_valid,
	input  logic                                             in_ready,
	input  logic [1:0]                                       op_code,
	input  logic                                             first_is_immediate,
	input  logic [rmes_pkg::FIELD_W-1:0]                     first_operand,
	input  logic                                             second_is_immediate,
	input  logic [rmes_pkg::FIELD_W-1:0]                     second_operand,
	input  logic                                             out_valid,
	input  logic                                             out_ready,
	input  logic [rmes_pkg::OUT_PC_W-1:0]                    next_counter,
	input  logic                                             halted,
	input  logic [rmes_pkg::DATA_W-1:0]                      written_value,
	input  logic [rmes_pkg::MUL_CNT_W-1:0]                   multiply_total,
	output int                                               fail_count,
	output int                                               pending,
	output rmes_pkg::pc_t                                    counter_now,
	output rmes_pkg::word_t [rmes_pkg::REG_COUNT-1:0]        regs_now
);

	typedef struct packed {
		logic [rmes_pkg::OUT_PC_W-1:0]  counter;
		logic                           halted;
		logic [rmes_pkg::DATA_W-1:0]    value;
		logic [rmes_pkg::MUL_CNT_W-1:0] muls;
	} step_result_t;

	rmes_pkg::word_t [rmes_pkg::REG_COUNT-1:0] regs;
	rmes_pkg::pc_t                             pc;
	logic                                      stopped;
	logic [rmes_pkg::MUL_CNT_W-1:0]            mult_tally;
	rmes_pkg::len_t                            prog_len;
	step_result_t                              expected_results[$];
	step_result_t                              want;

	assign regs_now    = regs;
	assign counter_now = pc;

	function automatic rmes_pkg::word_t fetch_operand(input logic imm, input logic [31:0] f);
		if (imm)
			return {{32{f[31]}}, f};
		if (f < 32'(rmes_pkg::REG_COUNT))
			return regs[f[rmes_pkg::IDX_W-1:0]];
		return '0;
	endfunction

	// Execute one instruction on the shadow machine and return the result it reports.
	function automatic step_result_t execute_instr(input logic [1:0] op, input logic fi,
			input logic [31:0] fo, input logic si, input logic [31:0] so);
		rmes_pkg::len_t  len;
		rmes_pkg::word_t target, cond, offs, src, old, result;
		step_result_t    r;
		len    = (prog_len > rmes_pkg::len_t'(rmes_pkg::PROGRAM_DEPTH)) ?
			rmes_pkg::len_t'(rmes_pkg::PROGRAM_DEPTH) : prog_len;
		result = '0;
		if (!stopped && {1'b0, pc} < len) begin
			target = 64'(pc) + 64'd1;
			if (op == rmes_pkg::OP_JNZ) begin
				cond = fetch_operand(fi, fo);
				offs = fetch_operand(si, so);
				if (cond != '0)
					target = 64'(pc) + offs;
			end else begin
				src = fetch_operand(si, so);
				old = fetch_operand(1'b0, fo);
				case (op)
					rmes_pkg::OP_SET: result = src;
					rmes_pkg::OP_SUB: result = old - src;
					rmes_pkg::OP_MUL: begin
						result = old * src;
						if (mult_tally != '1)
							mult_tally = mult_tally + 32'd1;
					end
					default: result = '0;
				endcase
				// drop writes to a register that does not exist
				if (fo < 32'(rmes_pkg::REG_COUNT))
					regs[fo[rmes_pkg::IDX_W-1:0]] = result;
			end
			// a target out of range stops the machine and holds the counter
			if (target < 64'(len))
				pc = target[rmes_pkg::PC_W-1:0];
			else
				stopped = 1'b1;
		end
		r.counter = pc;
		r.halted  = stopped || ({1'b0, pc} >= len);
		r.value   = result;
		r.muls    = mult_tally;
		return r;
	endfunction

	task automatic report_field(input string name, input logic [63:0] want_v,
			input logic [63:0] got_v);
		if (got_v !== want_v) begin
			fail_count++;
			$display("%0t %s: expected %0h, got %0h", $time, name, want_v, got_v);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < rmes_pkg::REG_COUNT; i++)
				regs[i] = '0;
			pc         = '0;
			stopped    = 1'b0;
			mult_tally = '0;
			prog_len   = '0;
			fail_count = 0;
			expected_results.delete();
			pending    = 0;
		end else begin
			if (cfg_we)
				prog_len = cfg_wdata;
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					fail_count++;
					$display("%0t result beat with nothing expected: counter %0h, value %0h",
						$time, next_counter, written_value);
				end else begin
					want = expected_results.pop_front();
					report_field("next_counter", 64'(want.counter), 64'(next_counter));
					report_field("halted", 64'(want.halted), 64'(halted));
					report_field("written_value", want.value, written_value);
					report_field("multiply_total", 64'(want.muls), 64'(multiply_total));
				end
			end
			if (in_valid && in_ready)
				expected_results.push_back(execute_instr(op_code, first_is_immediate,
					first_operand, second_is_immediate, second_operand));
			pending = expected_results.size();
		end
	end

endmodule

// ===== verif/register_machine_execute_step_tb.sv =====
// Testbench top for the register machine execute step: instruction stimulus, configuration and verdict.
`timescale 1ns / 100ps

module register_machine_execute_step_tb;

	import rmes_pkg::*;

	localparam int CYCLE_LIMIT = 200000;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    cfg_we = 1'b0;
	len_t                    cfg_wdata = '0;
	logic                    in_valid = 1'b0;
	logic                    in_ready;
	op_t                     op_code = OP_SET;
	logic                    first_is_immediate = 1'b0;
	logic [FIELD_W-1:0]      first_operand = '0;
	logic                    second_is_immediate = 1'b0;
	logic [FIELD_W-1:0]      second_operand = '0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic [OUT_PC_W-1:0]     next_counter;
	logic                    halted;
	logic [DATA_W-1:0]       written_value;
	logic [MUL_CNT_W-1:0]    multiply_total;

	int                      fail_count;
	int                      pending;
	pc_t                     counter_now;
	word_t [REG_COUNT-1:0]   regs_now;
	logic                    calm = 1'b0;
	len_t                    active_len = '0;
	int unsigned             cycles = 0;

	register_machine_execute_step i_dut (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cfg_we              (cfg_we),
		.cfg_wdata           (cfg_wdata),
		.in_valid            (in_valid),
		.in_ready            (in_ready),
		.op_code             (op_code),
		.first_is_immediate  (first_is_immediate),
		.first_operand       (first_operand),
		.second_is_immediate (second_is_immediate),
		.second_operand      (second_operand),
		.out_valid           (out_valid),
		.out_ready           (out_ready),
		.next_counter        (next_counter),
		.halted              (halted),
		.written_value       (written_value),
		.multiply_total      (multiply_total)
	);

	rmes_result_check i_check (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cfg_we              (cfg_we),
		.cfg_wdata           (cfg_wdata),
		.in_valid            (in_valid),
		.in_ready            (in_ready),
		.op_code             (op_code),
		.first_is_immediate  (first_is_immediate),
		.first_operand       (first_operand),
		.second_is_immediate (second_is_immediate),
		.second_operand      (second_operand),
		.out_valid           (out_valid),
		.out_ready           (out_ready),
		.next_counter        (next_counter),
		.halted              (halted),
		.written_value       (written_value),
		.multiply_total      (multiply_total),
		.fail_count          (fail_count),
		.pending             (pending),
		.counter_now         (counter_now),
		.regs_now            (regs_now)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(negedge clk) begin
		out_ready <= calm || ($urandom_range(99) >= 6);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("register_machine_execute_step test failed");
			$finish;
		end
	end

	function automatic logic [31:0] rand_imm();
		case ($urandom_range(7))
			0, 1: return $urandom();
			2: begin
				case ($urandom_range(4))
					0: return 32'h7fff_ffff;
					1: return 32'h8000_0000;
					2: return 32'hffff_ffff;
					3: return 32'h0000_0000;
					default: return 32'h0000_0001;
				endcase
			end
			3, 4, 5: return 32'($urandom_range(16)) - 32'd8;
			default: return 32'($urandom_range(2000)) - 32'd1000;
		endcase
	endfunction

	// mostly a real register, now and then an index beyond the file
	function automatic logic [31:0] rand_reg();
		if ($urandom_range(9) != 0)
			return 32'($urandom_range(REG_COUNT - 1));
		return $urandom() | 32'(REG_COUNT);
	endfunction

	function automatic word_t reg_value(input logic [31:0] idx);
		return (idx < 32'(REG_COUNT)) ? regs_now[idx[IDX_W-1:0]] : '0;
	endfunction

	// Entered at a falling edge; returns at the falling edge after the beat is taken.
	task automatic send_instr(input op_t op, input logic fi, input logic [31:0] fo,
			input logic si, input logic [31:0] so);
		while (!calm && $urandom_range(99) < 6) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid            <= 1'b1;
		op_code             <= op;
		first_is_immediate  <= fi;
		first_operand       <= fo;
		second_is_immediate <= si;
		second_operand      <= so;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	task automatic set_length(input len_t v);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we     <= 1'b0;
		active_len = (v > len_t'(PROGRAM_DEPTH)) ? len_t'(PROGRAM_DEPTH) : v;
	endtask

	task automatic jump_to(input logic [31:0] target);
		send_instr(OP_JNZ, 1'b1, $urandom() | 32'd1, 1'b1, target - 32'(counter_now));
	endtask

	task automatic issue_noise_instr();
		send_instr(op_t'($urandom_range(3)), 1'($urandom_range(1)), $urandom(),
			1'($urandom_range(1)), $urandom());
	endtask

	// Random instruction whose every outcome keeps the counter inside the program.
	task automatic issue_random_instr();
		pc_t         pc;
		op_t         op;
		logic        fi, si;
		logic [31:0] fo, so, idx;
		word_t       cond;
		int          r;
		pc = counter_now;
		if (32'(pc) + 32'd1 >= 32'(active_len)) begin
			jump_to(32'($urandom_range(active_len - 1)));
			return;
		end
		r  = $urandom_range(99);
		op = (r < 25) ? OP_SET : (r < 50) ? OP_SUB : (r < 70) ? OP_MUL : OP_JNZ;
		fi = 1'($urandom_range(1));
		si = 1'($urandom_range(1));
		if (op != OP_JNZ) begin
			fo = rand_reg();
			so = si ? rand_imm() : rand_reg();
		end else begin
			fo   = fi ? (($urandom_range(3) == 0) ? 32'd0 : rand_imm()) : rand_reg();
			cond = fi ? word_t'($signed(fo)) : reg_value(fo);
			if (cond == '0) begin
				so = si ? $urandom() : rand_reg();
			end else begin
				so = 32'($urandom_range(active_len - 1)) - 32'(pc);
				if (!si) begin
					// look for a register that holds a usable offset, else fall back
					si = 1'b1;
					for (int k = 0; k < 8 && si; k++) begin
						idx = 32'($urandom_range(REG_COUNT - 1));
						if (64'(pc) + reg_value(idx) < 64'(active_len)) begin
							si = 1'b0;
							so = idx;
						end
					end
				end
			end
		end
		send_instr(op, fi, fo, si, so);
	endtask

	initial begin
		logic [31:0] leap;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// zero length: the machine reads as halted
		set_length('0);
		repeat (3) issue_noise_instr();

		// lengths beyond the store act as the full depth
		set_length('1);
		send_instr(OP_SET, 1'b0, 32'd0, 1'b1, 32'h7fff_ffff);
		send_instr(OP_SET, 1'b1, 32'd1, 1'b1, 32'h8000_0000);
		send_instr(OP_SET, 1'b0, 32'd2, 1'b1, 32'hffff_ffff);
		send_instr(OP_SET, 1'b0, 32'd15, 1'b0, 32'd1);
		send_instr(OP_SUB, 1'b0, 32'd3, 1'b1, 32'h8000_0000);
		send_instr(OP_SUB, 1'b1, 32'd4, 1'b0, 32'd2);
		send_instr(OP_MUL, 1'b0, 32'd0, 1'b0, 32'd0);
		send_instr(OP_MUL, 1'b0, 32'd1, 1'b1, 32'hffff_ffff);
		send_instr(OP_MUL, 1'b0, 32'd15, 1'b0, 32'd15);
		send_instr(OP_MUL, 1'b1, 32'd15, 1'b0, 32'd15);
		// destinations beyond the file: value reported, write dropped; a source beyond the file reads as zero
		send_instr(OP_SET, 1'b0, 32'd16, 1'b1, 32'd5);
		send_instr(OP_SET, 1'b1, 32'hffff_ffff, 1'b0, 32'd0);
		send_instr(OP_SUB, 1'b0, 32'h8000_0000, 1'b1, 32'd1);
		send_instr(OP_SET, 1'b0, 32'd5, 1'b0, 32'hffff_fff0);
		// jumps: not taken, forward, backward, on register tests and offsets
		send_instr(OP_JNZ, 1'b1, 32'd0, 1'b1, 32'h7fff_ffff);
		send_instr(OP_JNZ, 1'b1, 32'd1, 1'b1, 32'd2);
		send_instr(OP_JNZ, 1'b1, 32'h8000_0000, 1'b1, 32'hffff_ffff);
		send_instr(OP_JNZ, 1'b0, 32'd4, 1'b1, 32'd1);
		send_instr(OP_JNZ, 1'b0, 32'd6, 1'b0, 32'd2);
		send_instr(OP_JNZ, 1'b0, 32'd20, 1'b1, 32'hffff_ff9c);
		send_instr(OP_SET, 1'b0, 32'd6, 1'b1, 32'd3);
		send_instr(OP_JNZ, 1'b0, 32'd4, 1'b0, 32'd6);
		send_instr(OP_JNZ, 1'b1, 32'hffff_ffff, 1'b1, 32'd0);
		send_instr(OP_MUL, 1'b0, 32'd7, 1'b1, 32'd0);
		send_instr(OP_SUB, 1'b0, 32'd8, 1'b0, 32'd0);

		repeat (500) issue_random_instr();

		jump_to(32'd0);
		set_length(len_t'(37));
		calm = 1'b1;
		repeat (400) issue_random_instr();
		calm = 1'b0;

		// shrink the length under the counter: halted without stopping
		drain();
		if (counter_now == '0)
			send_instr(OP_SET, 1'b0, 32'd9, 1'b1, rand_imm());
		drain();
		set_length(len_t'(counter_now));
		repeat (6) issue_noise_instr();
		set_length('1);

		jump_to(32'd0);
		set_length(len_t'(5));
		repeat (150) issue_random_instr();

		jump_to(32'd0);
		set_length(len_t'(1));
		repeat (10) issue_random_instr();

		set_length(len_t'(PROGRAM_DEPTH));
		repeat (400) issue_random_instr();

		// leave the program, below zero or past the end, then stay halted
		jump_to(32'd0);
		set_length(len_t'(64));
		repeat (10) issue_random_instr();
		if ($urandom_range(1))
			leap = -(32'(counter_now) + 32'd1 + 32'($urandom_range(100)));
		else
			leap = 32'(active_len) - 32'(counter_now) + 32'($urandom_range(100));
		send_instr(OP_JNZ, 1'b1, 32'd1, 1'b1, leap);
		repeat (60) issue_noise_instr();
		set_length('1);
		repeat (5) issue_noise_instr();

		drain();
		repeat (20) @(negedge clk);
		if (fail_count == 0)
			$display("register_machine_execute_step test passed");
		else
			$display("register_machine_execute_step test failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/rmes_pkg.sv
src/register_machine_execute_step.sv
src/rmes_checker.sv
verif/rmes_result_check.sv
verif/register_machine_execute_step_tb.sv
